>>> hdl/sse_pkg.sv
// Shared types, codes and name tables for the event stream parser.
`default_nettype none

package sse_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNul   = 8'h00;

  localparam logic [30:0] RetryMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    K_VALUE    = 2'd0,
    K_FEND     = 2'd1,
    K_DISPATCH = 2'd2,
    K_DISCARD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FK_EVENT   = 3'd0,
    FK_DATA    = 3'd1,
    FK_ID      = 3'd2,
    FK_RETRY   = 3'd3,
    FK_UNKNOWN = 3'd4
  } field_e;

  typedef enum logic [1:0] {
    LP_NAME    = 2'd0,
    LP_COLON   = 2'd1,
    LP_VALUE   = 2'd2,
    LP_COMMENT = 2'd3
  } line_phase_e;

  typedef enum logic [1:0] {
    NP_LEAD   = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_STOP   = 2'd3
  } num_phase_e;

  typedef struct packed {
    logic        id_given;
    logic        type_given;
    logic [30:0] retry_value;
    logic        retry_valid;
    logic        field_ok;
    logic [7:0]  value_byte;
    logic [1:0]  field_kind;
    kind_e       kind;
  } res_t;

  // name length per field kind
  function automatic logic [2:0] name_len(input logic [1:0] f);
    logic [2:0] l;
    case (f)
      2'd0:    l = 3'd5;
      2'd1:    l = 3'd4;
      2'd2:    l = 3'd2;
      default: l = 3'd5;
    endcase
    return l;
  endfunction

  // expected name character at a position
  function automatic logic [7:0] name_char(input logic [1:0] f, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (f)
      2'd0: begin
        case (pos)
          3'd0:    c = 8'h65; // e
          3'd1:    c = 8'h76; // v
          3'd2:    c = 8'h65; // e
          3'd3:    c = 8'h6E; // n
          3'd4:    c = 8'h74; // t
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    c = 8'h64; // d
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h74; // t
          3'd3:    c = 8'h61; // a
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    c = 8'h69; // i
          3'd1:    c = 8'h64; // d
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    c = 8'h72; // r
          3'd1:    c = 8'h65; // e
          3'd2:    c = 8'h74; // t
          3'd3:    c = 8'h72; // r
          3'd4:    c = 8'h79; // y
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sse_parser.sv
// Front end: line splitting, field name matching, retry number parsing, result build.
`default_nettype none

module sse_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_valid_i,
  input  wire logic [7:0]    byte_i,
  output sse_pkg::res_t      res_o,
  output logic               res_valid_o
);
  import sse_pkg::*;

  line_phase_e phase_q, phase_d;
  logic        line_empty_q, line_empty_d;
  logic        after_cr_q, after_cr_d;
  logic [2:0]  pos_q, pos_d;
  logic [3:0]  cand_q, cand_d;
  field_e      cur_q, cur_d;
  logic        id_nul_q, id_nul_d;
  num_phase_e  nphase_q, nphase_d;
  logic        neg_q, neg_d;
  logic        bad_q, bad_d;
  logic [30:0] acc_q, acc_d;
  logic        data_seen_q, data_seen_d;
  logic        type_seen_q, type_seen_d;
  logic        id_seen_q, id_seen_d;
  logic        rhv_q, rhv_d;
  logic [30:0] rheld_q, rheld_d;

  field_e      resolved;
  field_e      fe_field;
  logic        is_term;
  logic        crlf_tail;
  logic        val_take;
  logic        is_digit;
  logic        is_ws;
  logic        retry_ok;
  logic [34:0] acc_mul;
  logic [30:0] acc_next;

  always_comb begin
    resolved = FK_UNKNOWN;
    for (int c = 0; c < 4; c++) begin
      if (cand_q[c] && pos_q == name_len(2'(c))) begin
        resolved = field_e'(3'(c));
      end
    end
  end

  assign is_term   = (byte_i == ChCr) || (byte_i == ChLf);
  assign crlf_tail = after_cr_q && (byte_i == ChLf);
  assign fe_field  = (phase_q == LP_NAME) ? resolved : cur_q;
  assign val_take  = ((phase_q == LP_COLON) && (byte_i != ChSpace)) || (phase_q == LP_VALUE);
  assign is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_ws     = byte_i inside {ChSpace, ChTab, ChVt, ChFf};
  assign retry_ok  = !bad_q && (!neg_q || (acc_q == '0));
  assign acc_mul   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                   + {31'b0, 4'(byte_i - ChZero)};
  assign acc_next  = (acc_mul[34:31] != 4'b0) ? RetryMax : acc_mul[30:0];

  // next state
  always_comb begin
    phase_d      = phase_q;
    line_empty_d = line_empty_q;
    after_cr_d   = after_cr_q;
    pos_d        = pos_q;
    cand_d       = cand_q;
    cur_d        = cur_q;
    id_nul_d     = id_nul_q;
    nphase_d     = nphase_q;
    neg_d        = neg_q;
    bad_d        = bad_q;
    acc_d        = acc_q;
    data_seen_d  = data_seen_q;
    type_seen_d  = type_seen_q;
    id_seen_d    = id_seen_q;
    rhv_d        = rhv_q;
    rheld_d      = rheld_q;
    if (byte_valid_i) begin
      if (is_term) begin
        if (crlf_tail) begin
          after_cr_d = 1'b0;
        end else begin
          after_cr_d = (byte_i == ChCr);
          if (line_empty_q) begin
            data_seen_d = 1'b0;
            type_seen_d = 1'b0;
            id_seen_d   = 1'b0;
            rhv_d       = 1'b0;
            rheld_d     = '0;
          end else if (phase_q != LP_COMMENT) begin
            case (fe_field)
              FK_EVENT: type_seen_d = 1'b1;
              FK_DATA:  data_seen_d = 1'b1;
              FK_ID:    if (!id_nul_q) id_seen_d = 1'b1;
              FK_RETRY: begin
                if (retry_ok) begin
                  rheld_d = acc_q;
                  rhv_d   = 1'b1;
                end
              end
              default: ;
            endcase
          end
          phase_d      = LP_NAME;
          line_empty_d = 1'b1;
          pos_d        = '0;
          cand_d       = '1;
          cur_d        = FK_UNKNOWN;
          id_nul_d     = 1'b0;
          nphase_d     = NP_LEAD;
          neg_d        = 1'b0;
          bad_d        = 1'b0;
          acc_d        = '0;
        end
      end else begin
        after_cr_d   = 1'b0;
        line_empty_d = 1'b0;
        case (phase_q)
          LP_NAME: begin
            if (byte_i == ChColon) begin
              if (line_empty_q) begin
                phase_d = LP_COMMENT;
              end else begin
                phase_d = LP_COLON;
                cur_d   = resolved;
              end
            end else begin
              for (int c = 0; c < 4; c++) begin
                if (!(pos_q < name_len(2'(c)) && name_char(2'(c), pos_q) == byte_i)) begin
                  cand_d[c] = 1'b0;
                end
              end
              if (pos_q != 3'd7) pos_d = pos_q + 3'd1;
            end
          end
          LP_COLON: phase_d = LP_VALUE;
          default: ;
        endcase
        if (val_take) begin
          if (cur_q == FK_RETRY) begin
            if (nphase_q != NP_STOP) begin
              if (byte_i == ChNul) begin
                nphase_d = NP_STOP;
              end else if (nphase_q == NP_LEAD && is_ws) begin
                bad_d = 1'b1;
              end else if (nphase_q == NP_LEAD && (byte_i == ChPlus || byte_i == ChMinus)) begin
                neg_d    = (byte_i == ChMinus);
                bad_d    = 1'b1;
                nphase_d = NP_SIGN;
              end else if (!is_digit) begin
                bad_d    = 1'b1;
                nphase_d = NP_STOP;
              end else begin
                bad_d    = 1'b0;
                nphase_d = NP_DIGITS;
                acc_d    = acc_next;
              end
            end
          end else if (cur_q == FK_ID && byte_i == ChNul) begin
            id_nul_d = 1'b1;
          end
        end
      end
    end
  end

  // result
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (byte_valid_i) begin
      if (is_term) begin
        if (!crlf_tail) begin
          if (line_empty_q) begin
            res_valid_o = 1'b1;
            if (data_seen_q) begin
              res_o.kind        = K_DISPATCH;
              res_o.retry_valid = rhv_q;
              res_o.retry_value = rhv_q ? rheld_q : '0;
              res_o.type_given  = type_seen_q;
              res_o.id_given    = id_seen_q;
            end else begin
              res_o.kind = K_DISCARD;
            end
          end else if (phase_q != LP_COMMENT && fe_field != FK_UNKNOWN) begin
            res_valid_o      = 1'b1;
            res_o.kind       = K_FEND;
            res_o.field_kind = fe_field[1:0];
            case (fe_field)
              FK_ID:    res_o.field_ok = !id_nul_q;
              FK_RETRY: res_o.field_ok = retry_ok;
              default:  res_o.field_ok = 1'b1;
            endcase
          end
        end
      end else if (val_take && cur_q != FK_RETRY && cur_q != FK_UNKNOWN) begin
        res_valid_o      = 1'b1;
        res_o.kind       = K_VALUE;
        res_o.field_kind = cur_q[1:0];
        res_o.value_byte = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= LP_NAME;
      line_empty_q <= 1'b1;
      after_cr_q   <= 1'b0;
      pos_q        <= '0;
      cand_q       <= '1;
      cur_q        <= FK_UNKNOWN;
      id_nul_q     <= 1'b0;
      nphase_q     <= NP_LEAD;
      neg_q        <= 1'b0;
      bad_q        <= 1'b0;
      acc_q        <= '0;
      data_seen_q  <= 1'b0;
      type_seen_q  <= 1'b0;
      id_seen_q    <= 1'b0;
      rhv_q        <= 1'b0;
      rheld_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      line_empty_q <= line_empty_d;
      after_cr_q   <= after_cr_d;
      pos_q        <= pos_d;
      cand_q       <= cand_d;
      cur_q        <= cur_d;
      id_nul_q     <= id_nul_d;
      nphase_q     <= nphase_d;
      neg_q        <= neg_d;
      bad_q        <= bad_d;
      acc_q        <= acc_d;
      data_seen_q  <= data_seen_d;
      type_seen_q  <= type_seen_d;
      id_seen_q    <= id_seen_d;
      rhv_q        <= rhv_d;
      rheld_q      <= rheld_d;
    end
  end

  a_no_retry_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == K_VALUE) |-> (cur_q != FK_RETRY))
    else $error("value byte tagged for retry field");

  a_dispatch_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == K_DISPATCH) |-> data_seen_q)
    else $error("dispatch without data");

  a_held_retry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rhv_q |-> (rheld_q == '0))
    else $error("held retry nonzero while not valid");

  a_comment_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && phase_q == LP_COMMENT && !is_term) |-> !res_valid_o)
    else $error("result from comment line");

endmodule

`default_nettype wire

>>> hdl/sse_fifo.sv
// Result queue between the parser and the output channel.
`default_nettype none

module sse_fifo #(
  parameter int unsigned Depth = sse_pkg::FifoDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sse_pkg::res_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output sse_pkg::res_t      pop_data_o
);
  import sse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("count did not grow on push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("count did not shrink on pop");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

`default_nettype wire

>>> hdl/sse_event_stream_parser_top.sv
// Top level of the server-sent events stream parser.
//
// Input stream: one raw byte per word on s_axis (tdata[7:0]). Output stream:
// at most one result word per input byte on m_axis; tuser carries the result
// kind (value byte, field end, dispatch, discard), tdata the other fields.
// The parser updates its line state in the cycle a byte is accepted and
// writes the result, if any, into a small queue (FifoDepth words). The head
// of the queue drives m_axis directly, so a result is registered in the queue
// and appears on m_axis once the results ahead of it have been taken.
// Throughput is one byte per cycle while the queue is not full;
// s_axis_tready_o is low only while the queue is full, which happens
// only when the receiver holds m_axis_tready_i low; bytes that make no
// result still need a free slot to be taken.
// Reset (rst_ni low, asynchronous) empties the queue, puts the parser at the
// start of a line with no event gathered and no pending CR.
`default_nettype none

module sse_event_stream_parser_top #(
  parameter int unsigned FifoDepth = sse_pkg::FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [1:0] field_kind, [9:2] value_byte,
                                             // [10] field_ok, [11] retry_valid,
                                             // [42:12] retry_value, [43] type_given,
                                             // [44] id_given, [47:45] zero
  output logic [1:0]       m_axis_tuser_o    // [1:0] kind
);
  import sse_pkg::*;

  logic  accept;
  logic  res_valid;
  res_t  res;
  logic  full;
  res_t  head;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  sse_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (s_axis_tdata_i),
    .res_o        (res),
    .res_valid_o  (res_valid)
  );

  sse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (m_axis_tvalid_o),
    .pop_i       (m_axis_tready_i),
    .pop_data_o  (head)
  );

  assign m_axis_tuser_o = head.kind;
  assign m_axis_tdata_o = {3'b000, head.id_given, head.type_given, head.retry_value,
                           head.retry_valid, head.field_ok, head.value_byte,
                           head.field_kind};

endmodule

`default_nettype wire
